// ===== src/asrb_pkg.sv =====
// Shared types and constants for the serial interface register block.
// No dependencies.
package asrb_pkg;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_RX    = 2'd3;

  localparam int CNT_W = 10;

  localparam logic [1:0] DIV_16 = 2'd1;
  localparam logic [1:0] DIV_64 = 2'd2;

  localparam logic [CNT_W-1:0] TX_LEN_DIV1  = 10'd10;
  localparam logic [CNT_W-1:0] TX_LEN_DIV16 = 10'd160;
  localparam logic [CNT_W-1:0] TX_LEN_DIV64 = 10'd640;

  localparam int CTRL_RX_IRQ_EN = 7;

  typedef struct packed {
    logic [1:0] cmd;
    logic       reg_select;
    logic [7:0] data_byte;
    logic       framing_error;
    logic       parity_error;
  } request_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_line;
  } result_t;

endpackage

// ===== src/asrb_in_reg.sv =====
// Input register stage: holds one accepted request until the core takes it.
// Depends on asrb_pkg.
module asrb_in_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              request_valid,
  output logic              request_ready,
  input  asrb_pkg::request_t request,
  input  logic              advance,
  output logic              held_valid,
  output asrb_pkg::request_t held
);
  import asrb_pkg::*;

  assign request_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (request_ready) begin
      held_valid <= request_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (request_valid && request_ready) begin
      held <= request;
    end
  end

endmodule

// ===== src/asrb_regs.sv =====
// Register file and per-request update logic: data, status, control, tx countdown.
// Depends on asrb_pkg.
module asrb_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  asrb_pkg::request_t req,
  output asrb_pkg::result_t  rsp_next
);
  import asrb_pkg::*;

  logic [7:0]       rx_data, rx_data_next;
  logic [7:0]       control, control_next;
  logic [CNT_W-1:0] countdown, countdown_next;
  logic rx_full, rx_full_next;
  logic tx_empty, tx_empty_next;
  logic framing, framing_next;
  logic overrun, overrun_next;
  logic parity, parity_next;
  logic irq, irq_next;
  logic [7:0] status_byte;
  logic [CNT_W-1:0] tx_len;

  assign status_byte = {irq, parity, overrun, framing, 2'b00, tx_empty, rx_full};

  always_comb begin
    case (control[1:0])
      DIV_16:  tx_len = TX_LEN_DIV16;
      DIV_64:  tx_len = TX_LEN_DIV64;
      default: tx_len = TX_LEN_DIV1;
    endcase
  end

  always_comb begin
    rx_data_next   = rx_data;
    control_next   = control;
    countdown_next = countdown;
    rx_full_next   = rx_full;
    tx_empty_next  = tx_empty;
    framing_next   = framing;
    overrun_next   = overrun;
    parity_next    = parity;
    rsp_next.read_data = 8'd0;
    unique case (req.cmd)
      CMD_TICK: begin
        if (!tx_empty && countdown != '0) begin
          countdown_next = countdown - 1'b1;
          if (countdown == CNT_W'(1)) tx_empty_next = 1'b1;
        end
      end
      CMD_READ: begin
        if (req.reg_select) begin
          rsp_next.read_data = rx_data;
          rx_full_next       = 1'b0;
        end else begin
          rsp_next.read_data = status_byte;
        end
      end
      CMD_WRITE: begin
        if (req.reg_select) begin
          tx_empty_next  = 1'b0;
          countdown_next = tx_len;
        end else begin
          control_next = req.data_byte;
        end
      end
      CMD_RX: begin
        if (rx_full) begin
          overrun_next = 1'b1;
        end else begin
          rx_data_next = req.data_byte;
          rx_full_next = 1'b1;
          framing_next = framing | req.framing_error;
          parity_next  = parity | req.parity_error;
        end
      end
    endcase
    irq_next = control_next[CTRL_RX_IRQ_EN] & rx_full_next;
    rsp_next.irq_line = irq_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_data   <= 8'd0;
      control   <= 8'd0;
      countdown <= '0;
      rx_full   <= 1'b0;
      tx_empty  <= 1'b1;
      framing   <= 1'b0;
      overrun   <= 1'b0;
      parity    <= 1'b0;
      irq       <= 1'b0;
    end else if (step) begin
      rx_data   <= rx_data_next;
      control   <= control_next;
      countdown <= countdown_next;
      rx_full   <= rx_full_next;
      tx_empty  <= tx_empty_next;
      framing   <= framing_next;
      overrun   <= overrun_next;
      parity    <= parity_next;
      irq       <= irq_next;
    end
  end

  a_irq_level: assert property (@(posedge clk) disable iff (rst)
    irq == (control[CTRL_RX_IRQ_EN] && rx_full))
    else $error("irq bit out of step with enable and receive full");

  a_tx_busy_count: assert property (@(posedge clk) disable iff (rst)
    !tx_empty |-> countdown != '0)
    else $error("transmitter busy with zero countdown");

  a_errors_sticky: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && ($past(overrun) || $past(framing) || $past(parity))) |->
      ((overrun || !$past(overrun)) && (framing || !$past(framing)) &&
       (parity || !$past(parity))))
    else $error("sticky error flag cleared");

endmodule

// ===== src/acia_serial_register_block_unit.sv =====
// Top level of the serial interface register block: input stage, registers, result register.
// Depends on asrb_pkg, asrb_in_reg, asrb_regs.
//
// Each request (tick, bus read, bus write or received byte) yields exactly one result: the
// read byte (zero unless a bus read) and the interrupt level after the request. One request
// is taken per cycle unless the result register holds a result that is not yet taken. A result
// is registered in the result register as its request leaves the input stage and the status,
// control and countdown registers are updated.
module acia_serial_register_block_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               request_valid,
  output logic               request_ready,
  input  asrb_pkg::request_t request,
  output logic               result_valid,
  input  logic               result_ready,
  output asrb_pkg::result_t  result
);
  import asrb_pkg::*;

  logic     held_valid;
  request_t held;
  logic     advance;
  result_t  rsp_next;

  assign advance = held_valid && (!result_valid || result_ready);

  asrb_in_reg u_in (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_ready (request_ready),
    .request       (request),
    .advance       (advance),
    .held_valid    (held_valid),
    .held          (held)
  );

  asrb_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .req      (held),
    .rsp_next (rsp_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= rsp_next;
    end
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Testbench for acia_serial_register_block_unit: a directed table, then random requests,
// each result checked against an expected value from the table or a predictor of the status,
// control and countdown registers. Depends on asrb_pkg and the block's top level.
module tb;
  import asrb_pkg::*;

  localparam int ST_RX_FULL  = 0;
  localparam int ST_TX_EMPTY = 1;
  localparam int ST_FRAMING  = 4;
  localparam int ST_OVERRUN  = 5;
  localparam int ST_PARITY   = 6;
  localparam int ST_IRQ      = 7;

  localparam int RANDOM_REQUESTS = 910;
  localparam int LONG_HOLD       = 90;
  localparam int LONG_HOLD_AT    = 300;
  localparam int WATCHDOG_LIMIT  = 1000;
  localparam int DRAIN_CYCLES    = 10;

  typedef struct {
    request_t    req;
    int unsigned reps;
    bit          typed;
    result_t     want;
  } script_row_t;

  logic     clk;
  logic     rst;
  logic     request_valid;
  logic     request_ready;
  request_t request;
  logic     result_valid;
  logic     result_ready;
  result_t  result;

  logic [7:0]       rx_byte_q;
  logic [7:0]       stat_q;
  logic [7:0]       ctrl_q;
  logic [CNT_W-1:0] tx_left;

  result_t     pending_results[$];
  script_row_t script[$];
  int          mismatches;
  int          sent;
  int          idle_cycles;

  acia_serial_register_block_unit dut (
    .clk          (clk),
    .rst          (rst),
    .request_valid(request_valid),
    .request_ready(request_ready),
    .request      (request),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic result_t acia_apply(request_t r);
    result_t res;
    res.read_data = 8'h00;
    case (r.cmd)
      CMD_TICK: begin
        if (!stat_q[ST_TX_EMPTY] && tx_left != 0) begin
          tx_left = tx_left - 1'b1;
          if (tx_left == 0) stat_q[ST_TX_EMPTY] = 1'b1;
        end
      end
      CMD_READ: begin
        if (r.reg_select) begin
          res.read_data = rx_byte_q;
          stat_q[ST_RX_FULL] = 1'b0;
        end else begin
          res.read_data = stat_q;
        end
      end
      CMD_WRITE: begin
        if (r.reg_select) begin
          stat_q[ST_TX_EMPTY] = 1'b0;
          if (ctrl_q[1:0] == DIV_16) tx_left = TX_LEN_DIV16;
          else if (ctrl_q[1:0] == DIV_64) tx_left = TX_LEN_DIV64;
          else tx_left = TX_LEN_DIV1;
        end else begin
          ctrl_q = r.data_byte;
        end
      end
      default: begin
        if (stat_q[ST_RX_FULL]) begin
          stat_q[ST_OVERRUN] = 1'b1;
        end else begin
          rx_byte_q = r.data_byte;
          stat_q[ST_RX_FULL] = 1'b1;
          if (r.framing_error) stat_q[ST_FRAMING] = 1'b1;
          if (r.parity_error) stat_q[ST_PARITY] = 1'b1;
        end
      end
    endcase
    stat_q[ST_IRQ] = ctrl_q[CTRL_RX_IRQ_EN] & stat_q[ST_RX_FULL];
    res.irq_line = stat_q[ST_IRQ];
    return res;
  endfunction

  function automatic script_row_t row(logic [1:0] cmd, logic sel, logic [7:0] data,
                                      logic fe, logic pe, int unsigned reps, bit typed,
                                      logic [7:0] rd, logic irq);
    script_row_t s;
    s.req.cmd           = cmd;
    s.req.reg_select    = sel;
    s.req.data_byte     = data;
    s.req.framing_error = fe;
    s.req.parity_error  = pe;
    s.reps              = reps;
    s.typed             = typed;
    s.want.read_data    = rd;
    s.want.irq_line     = irq;
    return s;
  endfunction

  function automatic request_t rand_request();
    request_t r;
    int pick;
    r = request_t'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 40) r.cmd = CMD_TICK;
    else if (pick < 65) r.cmd = CMD_READ;
    else if (pick < 80) r.cmd = CMD_WRITE;
    else r.cmd = CMD_RX;
    // keep most transmit times short so the countdown runs out often
    if (r.cmd == CMD_WRITE && !r.reg_select && $urandom_range(0, 9) < 7)
      r.data_byte[1:0] = $urandom_range(0, 1) ? 2'b11 : 2'b00;
    return r;
  endfunction

  // every third stretch of 80 runs with no idling
  function automatic int gap_for(int idx);
    if ((idx / 80) % 3 == 0) return 0;
    return $urandom_range(0, 7);
  endfunction

  task automatic send(request_t r, bit typed, result_t want);
    int gap;
    result_t predicted;
    gap = gap_for(sent);
    predicted = acia_apply(r);
    pending_results.push_back(typed ? want : predicted);
    if (gap > 0) begin
      request_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    request       <= r;
    request_valid <= 1'b1;
    do @(posedge clk); while (!request_ready);
    sent++;
  endtask

  initial begin
    script_row_t s;
    rst           = 1'b1;
    request_valid = 1'b0;
    request       = '0;
    mismatches    = 0;
    sent          = 0;
    rx_byte_q     = 8'h00;
    stat_q        = 8'h02;
    ctrl_q        = 8'h00;
    tx_left       = '0;

    script.push_back(row(CMD_READ,  1'b0, 8'h00, 1'b0, 1'b0, 1, 1'b1, 8'h02, 1'b0));
    script.push_back(row(CMD_READ,  1'b1, 8'hFF, 1'b1, 1'b1, 1, 1'b1, 8'h00, 1'b0));
    script.push_back(row(CMD_TICK,  1'b0, 8'h00, 1'b0, 1'b0, 1, 1'b1, 8'h00, 1'b0));
    script.push_back(row(CMD_WRITE, 1'b0, 8'h80, 1'b0, 1'b0, 1, 1'b1, 8'h00, 1'b0));
    script.push_back(row(CMD_RX,    1'b0, 8'hFF, 1'b1, 1'b1, 1, 1'b1, 8'h00, 1'b1));
    script.push_back(row(CMD_READ,  1'b0, 8'h00, 1'b0, 1'b0, 1, 1'b1, 8'hD3, 1'b1));
    // dropped byte: error inputs ignored, overrun set
    script.push_back(row(CMD_RX,    1'b1, 8'h00, 1'b1, 1'b0, 1, 1'b1, 8'h00, 1'b1));
    script.push_back(row(CMD_READ,  1'b0, 8'h00, 1'b0, 1'b0, 1, 1'b1, 8'hF3, 1'b1));
    script.push_back(row(CMD_READ,  1'b1, 8'h00, 1'b0, 1'b0, 1, 1'b1, 8'hFF, 1'b0));
    script.push_back(row(CMD_READ,  1'b0, 8'h00, 1'b0, 1'b0, 1, 1'b1, 8'h72, 1'b0));
    script.push_back(row(CMD_RX,    1'b0, 8'hA5, 1'b0, 1'b0, 1, 1'b0, 8'h00, 1'b0));
    script.push_back(row(CMD_WRITE, 1'b0, 8'h03, 1'b0, 1'b0, 1, 1'b0, 8'h00, 1'b0));
    script.push_back(row(CMD_READ,  1'b1, 8'h00, 1'b0, 1'b0, 1, 1'b0, 8'h00, 1'b0));
    // divider code 3 behaves as code 0: ten ticks
    script.push_back(row(CMD_WRITE, 1'b1, 8'h00, 1'b0, 1'b0, 1, 1'b1, 8'h00, 1'b0));
    script.push_back(row(CMD_TICK,  1'b0, 8'h00, 1'b0, 1'b0, 9, 1'b1, 8'h00, 1'b0));
    script.push_back(row(CMD_READ,  1'b0, 8'h00, 1'b0, 1'b0, 1, 1'b1, 8'h70, 1'b0));
    script.push_back(row(CMD_TICK,  1'b0, 8'h00, 1'b0, 1'b0, 1, 1'b1, 8'h00, 1'b0));
    script.push_back(row(CMD_READ,  1'b0, 8'h00, 1'b0, 1'b0, 1, 1'b1, 8'h72, 1'b0));
    script.push_back(row(CMD_TICK,  1'b1, 8'hFF, 1'b1, 1'b1, 1, 1'b1, 8'h00, 1'b0));
    script.push_back(row(CMD_WRITE, 1'b0, 8'h81, 1'b0, 1'b0, 1, 1'b0, 8'h00, 1'b0));
    script.push_back(row(CMD_WRITE, 1'b1, 8'h00, 1'b0, 1'b0, 1, 1'b0, 8'h00, 1'b0));
    script.push_back(row(CMD_TICK,  1'b0, 8'h00, 1'b0, 1'b0, 5, 1'b0, 8'h00, 1'b0));
    // write while busy restarts the countdown
    script.push_back(row(CMD_WRITE, 1'b1, 8'h55, 1'b0, 1'b0, 1, 1'b0, 8'h00, 1'b0));
    script.push_back(row(CMD_WRITE, 1'b0, 8'h02, 1'b0, 1'b0, 1, 1'b0, 8'h00, 1'b0));
    script.push_back(row(CMD_WRITE, 1'b1, 8'h00, 1'b0, 1'b0, 1, 1'b0, 8'h00, 1'b0));
    script.push_back(row(CMD_READ,  1'b0, 8'h00, 1'b0, 1'b0, 1, 1'b1, 8'h70, 1'b0));
    script.push_back(row(CMD_RX,    1'b0, 8'h5A, 1'b0, 1'b1, 1, 1'b0, 8'h00, 1'b0));
    script.push_back(row(CMD_WRITE, 1'b0, 8'h00, 1'b0, 1'b0, 1, 1'b0, 8'h00, 1'b0));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      s = script[i];
      repeat (s.reps) send(s.req, s.typed, s.want);
    end
    repeat (RANDOM_REQUESTS) send(rand_request(), 1'b0, '0);

    request_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("acia_serial_register_block_unit: match");
    else $display("acia_serial_register_block_unit: mismatch");
    $finish;
  end

  // result side: random hold per result, one long hold to back up the input
  initial begin
    int hold;
    int taken;
    result_ready = 1'b0;
    hold  = 0;
    taken = 0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && result_ready) begin
        taken++;
        hold = (taken == LONG_HOLD_AT) ? LONG_HOLD : gap_for(taken);
      end
      if (hold > 0) begin
        result_ready <= 1'b0;
        hold--;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result read_data %02h irq_line %0b",
                 $time, result.read_data, result.irq_line);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (result.read_data !== want.read_data) begin
          $display("%0t: read_data expected %02h actual %02h",
                   $time, want.read_data, result.read_data);
          mismatches++;
        end
        if (result.irq_line !== want.irq_line) begin
          $display("%0t: irq_line expected %0b actual %0b",
                   $time, want.irq_line, result.irq_line);
          mismatches++;
        end
      end
    end
  end

  initial idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (request_valid && request_ready) || (result_valid && result_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
        $display("acia_serial_register_block_unit: mismatch");
        $finish;
      end
    end
  end

endmodule
